@@ rtl/awd_pkg.sv @@
`timescale 1ns / 1ps

package awd_pkg;

    // Curve tables
    localparam int CURVE_TABLE_BITS = 10;
    localparam int TAB_N            = 1 << CURVE_TABLE_BITS;
    localparam int ADDR_W           = CURVE_TABLE_BITS + 1;
    localparam int ENTRY_W          = 24;
    localparam int SH_ATAN          = 23 - CURVE_TABLE_BITS;
    localparam int SH_WIDE          = 27 - CURVE_TABLE_BITS;
    localparam int FRAC_W           = SH_WIDE;
    localparam int PROD_W           = ENTRY_W + FRAC_W;

    // Datapath widths
    localparam int SAMPLE_W    = 24;
    localparam int MAG_W       = 24;
    localparam int GAIN_W      = 16;
    localparam int LEVEL_W     = 17;
    localparam int Q_FRAC      = 23;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int GAIN_SHIFT  = 8;
    localparam int GP_W        = MAG_W + GAIN_W;
    localparam int DRV_W       = 31;
    localparam int LEVEL_SHIFT = 16;
    localparam int LP_W        = ENTRY_W + LEVEL_W;
    localparam int LVL_W       = LP_W - LEVEL_SHIFT;

    // Reciprocal 2^46 / m, restoring division
    localparam int RECIP_SHIFT = 2 * Q_FRAC;
    localparam int DIV_Q_W     = 24;
    localparam int DIV_STEP    = 4;
    localparam int DIV_STAGES  = DIV_Q_W / DIV_STEP;
    localparam int REM_W       = DRV_W + 1;
    localparam int DIV_INIT    = 1 << (RECIP_SHIFT - DIV_Q_W);

    localparam logic [MAG_W-1:0]    ONE23   = 24'h800000;
    localparam logic [SAMPLE_W-1:0] SAT_POS = 24'h7FFFFF;
    localparam logic [SAMPLE_W-1:0] SAT_NEG = 24'h800000;

    // Pipeline stage positions
    localparam int ST_IN      = 0;
    localparam int ST_CONV    = 1;
    localparam int ST_GAIN    = 2;
    localparam int ST_DIV0    = 3;
    localparam int ST_ADDR    = ST_DIV0 + DIV_STAGES;
    localparam int ST_ROM     = ST_ADDR + 1;
    localparam int ST_MUL     = ST_ROM + 1;
    localparam int ST_SHAPE   = ST_MUL + 1;
    localparam int ST_LEVEL   = ST_SHAPE + 1;
    localparam int ST_OUT     = ST_LEVEL + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    // Configuration
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;
    localparam logic [CFG_INDEX_W-1:0] REG_BYPASS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CURVE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CONV    = 3'd4;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd256;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 17'd65536;

    localparam logic [1:0] CURVE_CLAMP = 2'd0;
    localparam logic [1:0] CURVE_ATAN  = 2'd1;
    localparam logic [1:0] CURVE_TANH  = 2'd2;
    localparam logic [1:0] CURVE_EXP   = 2'd3;

    localparam logic [1:0] CONV_LINEAR = 2'd0;
    localparam logic [1:0] CONV_FULL   = 2'd1;
    localparam logic [1:0] CONV_HALF   = 2'd2;
    localparam logic [1:0] CONV_SQUARE = 2'd3;

    typedef struct packed {
        logic                neg;
        logic [SAMPLE_W-1:0] raw;
    } ctx_t;

    typedef logic [ENTRY_W-1:0] curve_rom_t [0:TAB_N];

    localparam logic [63:0] ONE30  = 64'd1 << 30;
    localparam logic [63:0] HALF30 = 64'd1 << 29;

    // pi in Q.30 from its decimal digits, and the derived constants
    localparam logic [63:0] PI_E9       = 64'd1000000000;
    localparam logic [63:0] PI_HI       = 64'd3141592653 << 30;
    localparam logic [63:0] PI_Q30      = PI_HI / PI_E9
                                          + ((PI_HI % PI_E9) * PI_E9
                                             + (64'd589793238 << 30)
                                             + 64'd500000000000000000)
                                          / (PI_E9 * PI_E9);
    localparam logic [63:0] QUARTER_PI  = (PI_Q30 + 64'd2) >> 2;
    localparam logic [63:0] TWO_OVER_PI = ((64'd1 << 61) + (PI_Q30 >> 1)) / PI_Q30;

    // n / d by shift and subtract, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-y), Q.30 in and out
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] y);
        logic [63:0] z;
        logic [63:0] sum;
        logic [63:0] term;
        z    = y >> 6;
        sum  = ONE30;
        term = ONE30;
        for (int k = 1; k <= 14; k++)
        begin
            term = ((term * z + HALF30) >> 30) / 64'(k);
            if ((k & 1) != 0)
                sum = sum - term;
            else
                sum = sum + term;
        end
        for (int j = 0; j < 6; j++)
            sum = (sum * sum + HALF30) >> 30;
        return sum;
    endfunction

    // atan(r), odd series, Q.30
    function automatic logic [63:0] atan_series_q30(input logic [63:0] r);
        logic [63:0] r2;
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] c;
        r2  = (r * r + HALF30) >> 30;
        p   = r;
        sum = '0;
        for (int k = 0; k < 24; k++)
        begin
            c = p / 64'(2 * k + 1);
            if ((k & 1) != 0)
                sum = sum - c;
            else
                sum = sum + c;
            p = (p * r2 + HALF30) >> 30;
        end
        return sum;
    endfunction

    // Table contents, worked out at elaboration
    function automatic curve_rom_t build_rom(input logic [1:0] kind);
        curve_rom_t  rom;
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] at;
        logic [63:0] y;
        logic [63:0] e;
        for (int i = 0; i <= TAB_N; i++)
        begin
            if (kind == CURVE_ATAN)
            begin
                x = 64'(i) << (30 - CURVE_TABLE_BITS);
                if (x <= (ONE30 >> 1))
                    at = atan_series_q30(x);
                else
                begin
                    r  = udiv64(((ONE30 - x) << 30) + ((ONE30 + x) >> 1), ONE30 + x);
                    at = QUARTER_PI - atan_series_q30(r);
                end
                rom[i] = ENTRY_W'((at * TWO_OVER_PI + (64'd1 << 36)) >> 37);
            end
            else if (kind == CURVE_TANH)
            begin
                y      = 64'(i) << (34 - CURVE_TABLE_BITS);
                e      = exp_neg_q30(y << 1);
                rom[i] = ENTRY_W'(udiv64(((ONE30 - e) << 23) + ((ONE30 + e) >> 1),
                                         ONE30 + e));
            end
            else
            begin
                y      = 64'(i) << (34 - CURVE_TABLE_BITS);
                e      = exp_neg_q30(y);
                rom[i] = ENTRY_W'((ONE30 - e + 64'd64) >> 7);
            end
        end
        return rom;
    endfunction

    localparam curve_rom_t ATAN_ROM = build_rom(CURVE_ATAN);
    localparam curve_rom_t TANH_ROM = build_rom(CURVE_TANH);
    localparam curve_rom_t EXP_ROM  = build_rom(CURVE_EXP);

endpackage

@@ rtl/audio_waveshaping_distortion.sv @@
// Waveshaping distortion, 15 register stages from input to output register.
// Throughput: one sample per cycle; any empty stage absorbs an output stall.
// The atan reciprocal is a 6-stage restoring divider, 4 quotient bits a stage.
// Reset (rst_n low, async) empties the pipe and loads the register defaults;
// the curve tables are constant and need no clearing.
`timescale 1ns / 1ps

module audio_waveshaping_distortion
(
    input  logic                              clk,
    input  logic                              rst_n,
    // config write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [awd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [awd_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [awd_pkg::SAMPLE_W-1:0]      s_axis_tdata,   // [23:0] sample_in
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [awd_pkg::SAMPLE_W-1:0]      m_axis_tdata    // [23:0] sample_out
);

    // ---------------- configuration ----------------
    logic                          bypass_reg;
    logic [awd_pkg::GAIN_W-1:0]    gain_reg;
    logic [awd_pkg::LEVEL_W-1:0]   level_reg;
    logic [1:0]                    curve_reg;
    logic [1:0]                    conv_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg <= 1'b0;
            gain_reg   <= awd_pkg::GAIN_RESET;
            level_reg  <= awd_pkg::LEVEL_RESET;
            curve_reg  <= awd_pkg::CURVE_CLAMP;
            conv_reg   <= awd_pkg::CONV_LINEAR;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                awd_pkg::REG_BYPASS: bypass_reg <= cfg_data[0];
                awd_pkg::REG_GAIN:   gain_reg   <= cfg_data[awd_pkg::GAIN_W-1:0];
                awd_pkg::REG_LEVEL:  level_reg  <= cfg_data[awd_pkg::LEVEL_W-1:0];
                awd_pkg::REG_CURVE:  curve_reg  <= cfg_data[1:0];
                awd_pkg::REG_CONV:   conv_reg   <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [awd_pkg::NUM_STAGES-1:0] valid_reg;
    logic [awd_pkg::NUM_STAGES-1:0] adv;

    // a stage loads when it is empty or its successor loads
    always_comb
    begin
        adv[awd_pkg::NUM_STAGES-1] = !valid_reg[awd_pkg::NUM_STAGES-1] || m_axis_tready;
        for (int i = awd_pkg::NUM_STAGES - 2; i >= 0; i--)
            adv[i] = !valid_reg[i] || adv[i+1];
    end

    assign s_axis_tready = adv[awd_pkg::ST_IN];
    assign m_axis_tvalid = valid_reg[awd_pkg::ST_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (adv[awd_pkg::ST_IN])
                valid_reg[awd_pkg::ST_IN] <= s_axis_tvalid;
            for (int i = 1; i < awd_pkg::NUM_STAGES; i++)
                if (adv[i])
                    valid_reg[i] <= valid_reg[i-1];
        end
    end

    // sign and raw sample ride alongside the data
    awd_pkg::ctx_t ctx_reg [awd_pkg::NUM_STAGES];

    // ---------------- stage 1: amplitude conversion ----------------
    logic [awd_pkg::MAG_W-1:0] abs_c;
    logic [awd_pkg::SQ_W-1:0]  sq_c;
    logic [awd_pkg::SQ_W-1:0]  sq_rnd_c;
    logic [awd_pkg::MAG_W-1:0] conv_mag_c;
    logic                      conv_neg_c;
    logic [awd_pkg::MAG_W-1:0] mag_reg;
    logic                      x_neg;

    assign x_neg = ctx_reg[awd_pkg::ST_IN].raw[awd_pkg::SAMPLE_W-1];

    always_comb
    begin
        // minus one gives 0x800000, read as +1.0 unsigned
        abs_c    = x_neg ? ('0 - ctx_reg[awd_pkg::ST_IN].raw) : ctx_reg[awd_pkg::ST_IN].raw;
        sq_c     = awd_pkg::SQ_W'(abs_c) * awd_pkg::SQ_W'(abs_c);
        sq_rnd_c = sq_c + (awd_pkg::SQ_W'(1) << (awd_pkg::Q_FRAC - 1));
        unique case (conv_reg)
            awd_pkg::CONV_LINEAR:
            begin
                conv_mag_c = abs_c;
                conv_neg_c = x_neg;
            end
            awd_pkg::CONV_FULL:
            begin
                conv_mag_c = abs_c;
                conv_neg_c = 1'b0;
            end
            awd_pkg::CONV_HALF:
            begin
                conv_mag_c = x_neg ? '0 : abs_c;
                conv_neg_c = 1'b0;
            end
            awd_pkg::CONV_SQUARE:
            begin
                conv_mag_c = sq_rnd_c[awd_pkg::Q_FRAC +: awd_pkg::MAG_W];
                conv_neg_c = 1'b0;
            end
        endcase
    end

    // ---------------- stage 2: drive gain ----------------
    logic [awd_pkg::GP_W-1:0]  gp_c;
    logic [awd_pkg::DRV_W-1:0] drive_reg;

    assign gp_c = awd_pkg::GP_W'(mag_reg) * awd_pkg::GP_W'(gain_reg)
                  + (awd_pkg::GP_W'(1) << (awd_pkg::GAIN_SHIFT - 1));

    // ---------------- stages 3..8: reciprocal divider ----------------
    logic [awd_pkg::REM_W-1:0]   div_rem_reg [awd_pkg::DIV_STAGES];
    logic [awd_pkg::DIV_Q_W-1:0] div_q_reg   [awd_pkg::DIV_STAGES];
    logic [awd_pkg::DRV_W-1:0]   div_m_reg   [awd_pkg::DIV_STAGES];

    for (genvar k = 0; k < awd_pkg::DIV_STAGES; k++)
    begin : g_div
        logic [awd_pkg::REM_W-1:0]   rem_in;
        logic [awd_pkg::DIV_Q_W-1:0] q_in;
        logic [awd_pkg::DRV_W-1:0]   m_in;
        logic [awd_pkg::REM_W-1:0]   rem_c;
        logic [awd_pkg::DIV_Q_W-1:0] q_c;

        if (k == 0)
        begin : g_first
            // numerator 2^46 + m/2, top part seeds the remainder
            assign rem_in = awd_pkg::REM_W'(awd_pkg::DIV_INIT)
                            + awd_pkg::REM_W'(drive_reg[awd_pkg::DRV_W-1:awd_pkg::DIV_Q_W+1]);
            assign q_in   = '0;
            assign m_in   = drive_reg;
        end
        else
        begin : g_next
            assign rem_in = div_rem_reg[k-1];
            assign q_in   = div_q_reg[k-1];
            assign m_in   = div_m_reg[k-1];
        end

        always_comb
        begin
            rem_c = rem_in;
            q_c   = q_in;
            for (int j = 0; j < awd_pkg::DIV_STEP; j++)
            begin
                // numerator bit (m/2)[b] is m[b+1]
                rem_c = {rem_c[awd_pkg::REM_W-2:0],
                         m_in[awd_pkg::DIV_Q_W - k * awd_pkg::DIV_STEP - j]};
                if (rem_c >= awd_pkg::REM_W'(m_in))
                begin
                    rem_c = rem_c - awd_pkg::REM_W'(m_in);
                    q_c   = {q_c[awd_pkg::DIV_Q_W-2:0], 1'b1};
                end
                else
                    q_c   = {q_c[awd_pkg::DIV_Q_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[awd_pkg::ST_DIV0 + k])
            begin
                div_rem_reg[k] <= rem_c;
                div_q_reg[k]   <= q_c;
                div_m_reg[k]   <= m_in;
            end
        end
    end

    // ---------------- stage 9: table address ----------------
    logic [awd_pkg::DRV_W-1:0]            m9;
    logic [awd_pkg::DIV_Q_W-1:0]          q9;
    logic                                 over_c;
    logic [awd_pkg::DRV_W-1:0]            t_c;
    logic                                 sat_c;
    logic [awd_pkg::CURVE_TABLE_BITS-1:0] idx_c;
    logic [awd_pkg::FRAC_W-1:0]           frac_c;
    logic [awd_pkg::ADDR_W-1:0]           a0_reg;
    logic [awd_pkg::ADDR_W-1:0]           a1_reg;
    logic [awd_pkg::FRAC_W-1:0]           frac9_reg;
    logic                                 over9_reg;
    logic [awd_pkg::MAG_W-1:0]            clamp9_reg;

    assign m9     = div_m_reg[awd_pkg::DIV_STAGES-1];
    assign q9     = div_q_reg[awd_pkg::DIV_STAGES-1];
    assign over_c = m9 > awd_pkg::DRV_W'(awd_pkg::ONE23);

    always_comb
    begin
        unique case (curve_reg)
            awd_pkg::CURVE_ATAN:
            begin
                // above one the table is read at 1/m
                t_c    = over_c ? awd_pkg::DRV_W'(q9) : m9;
                sat_c  = (t_c >> awd_pkg::Q_FRAC) != '0;
                idx_c  = t_c[awd_pkg::SH_ATAN +: awd_pkg::CURVE_TABLE_BITS];
                frac_c = {{(awd_pkg::FRAC_W - awd_pkg::SH_ATAN){1'b0}},
                          t_c[awd_pkg::SH_ATAN-1:0]};
            end
            awd_pkg::CURVE_CLAMP, awd_pkg::CURVE_TANH, awd_pkg::CURVE_EXP:
            begin
                t_c    = m9;
                sat_c  = (t_c >> (awd_pkg::SH_WIDE + awd_pkg::CURVE_TABLE_BITS)) != '0;
                idx_c  = t_c[awd_pkg::SH_WIDE +: awd_pkg::CURVE_TABLE_BITS];
                frac_c = t_c[awd_pkg::SH_WIDE-1:0];
            end
        endcase
    end

    // ---------------- stage 10: table read ----------------
    logic [awd_pkg::ENTRY_W-1:0] lo_reg;
    logic [awd_pkg::ENTRY_W-1:0] nx_reg;
    logic [awd_pkg::FRAC_W-1:0]  frac10_reg;
    logic                        over10_reg;
    logic [awd_pkg::MAG_W-1:0]   clamp10_reg;

    // ---------------- stage 11: interpolation product ----------------
    logic                        up_c;
    logic [awd_pkg::ENTRY_W-1:0] diff_c;
    logic [awd_pkg::PROD_W-1:0]  prod_reg;
    logic                        up_reg;
    logic [awd_pkg::ENTRY_W-1:0] lo11_reg;
    logic                        over11_reg;
    logic [awd_pkg::MAG_W-1:0]   clamp11_reg;

    assign up_c   = nx_reg >= lo_reg;
    assign diff_c = up_c ? (nx_reg - lo_reg) : (lo_reg - nx_reg);

    // ---------------- stage 12: rounding and curve select ----------------
    logic [awd_pkg::PROD_W:0]    rsum_atan_c;
    logic [awd_pkg::PROD_W:0]    rsum_wide_c;
    logic [awd_pkg::ENTRY_W-1:0] rnd_c;
    logic [awd_pkg::ENTRY_W-1:0] interp_c;
    logic [awd_pkg::ENTRY_W-1:0] shaped_c;
    logic [awd_pkg::ENTRY_W-1:0] shaped_reg;

    assign rsum_atan_c = (awd_pkg::PROD_W+1)'(prod_reg)
                         + ((awd_pkg::PROD_W+1)'(1) << (awd_pkg::SH_ATAN - 1));
    assign rsum_wide_c = (awd_pkg::PROD_W+1)'(prod_reg)
                         + ((awd_pkg::PROD_W+1)'(1) << (awd_pkg::SH_WIDE - 1));

    always_comb
    begin
        if (curve_reg == awd_pkg::CURVE_ATAN)
            rnd_c = awd_pkg::ENTRY_W'(rsum_atan_c >> awd_pkg::SH_ATAN);
        else
            rnd_c = awd_pkg::ENTRY_W'(rsum_wide_c >> awd_pkg::SH_WIDE);
        interp_c = up_reg ? (lo11_reg + rnd_c) : (lo11_reg - rnd_c);
        unique case (curve_reg)
            awd_pkg::CURVE_CLAMP: shaped_c = clamp11_reg;
            awd_pkg::CURVE_ATAN:  shaped_c = over11_reg ? (awd_pkg::ONE23 - interp_c) : interp_c;
            awd_pkg::CURVE_TANH,
            awd_pkg::CURVE_EXP:   shaped_c = interp_c;
        endcase
    end

    // ---------------- stage 13: output level ----------------
    logic [awd_pkg::LP_W-1:0]  lp_c;
    logic [awd_pkg::LVL_W-1:0] lvl_reg;

    assign lp_c = awd_pkg::LP_W'(shaped_reg) * awd_pkg::LP_W'(level_reg)
                  + (awd_pkg::LP_W'(1) << (awd_pkg::LEVEL_SHIFT - 1));

    // ---------------- stage 14: sign, saturation, bypass ----------------
    logic [awd_pkg::SAMPLE_W-1:0] sample_out_next;
    logic [awd_pkg::SAMPLE_W-1:0] sample_out_reg;

    always_comb
    begin
        if (bypass_reg)
            sample_out_next = ctx_reg[awd_pkg::ST_LEVEL].raw;
        else if (ctx_reg[awd_pkg::ST_LEVEL].neg)
            sample_out_next = (lvl_reg > awd_pkg::LVL_W'(awd_pkg::ONE23))
                              ? awd_pkg::SAT_NEG
                              : ('0 - lvl_reg[awd_pkg::SAMPLE_W-1:0]);
        else
            sample_out_next = (lvl_reg > awd_pkg::LVL_W'(awd_pkg::SAT_POS))
                              ? awd_pkg::SAT_POS
                              : lvl_reg[awd_pkg::SAMPLE_W-1:0];
    end

    assign m_axis_tdata = sample_out_reg;

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (adv[awd_pkg::ST_IN])
        begin
            ctx_reg[awd_pkg::ST_IN].neg <= 1'b0;
            ctx_reg[awd_pkg::ST_IN].raw <= s_axis_tdata;
        end

        if (adv[awd_pkg::ST_CONV])
        begin
            mag_reg                       <= conv_mag_c;
            ctx_reg[awd_pkg::ST_CONV].neg <= conv_neg_c;
            ctx_reg[awd_pkg::ST_CONV].raw <= ctx_reg[awd_pkg::ST_IN].raw;
        end

        for (int i = awd_pkg::ST_GAIN; i < awd_pkg::NUM_STAGES; i++)
            if (adv[i])
                ctx_reg[i] <= ctx_reg[i-1];

        if (adv[awd_pkg::ST_GAIN])
            drive_reg <= gp_c[awd_pkg::GAIN_SHIFT +: awd_pkg::DRV_W];

        if (adv[awd_pkg::ST_ADDR])
        begin
            // saturated: both reads hit the last entry, fraction zero
            a0_reg     <= sat_c ? awd_pkg::ADDR_W'(awd_pkg::TAB_N) : {1'b0, idx_c};
            a1_reg     <= sat_c ? awd_pkg::ADDR_W'(awd_pkg::TAB_N)
                                : ({1'b0, idx_c} + awd_pkg::ADDR_W'(1));
            frac9_reg  <= sat_c ? '0 : frac_c;
            over9_reg  <= over_c;
            clamp9_reg <= over_c ? awd_pkg::ONE23 : m9[awd_pkg::MAG_W-1:0];
        end

        if (adv[awd_pkg::ST_ROM])
        begin
            unique case (curve_reg)
                awd_pkg::CURVE_ATAN:
                begin
                    lo_reg <= awd_pkg::ATAN_ROM[a0_reg];
                    nx_reg <= awd_pkg::ATAN_ROM[a1_reg];
                end
                awd_pkg::CURVE_TANH:
                begin
                    lo_reg <= awd_pkg::TANH_ROM[a0_reg];
                    nx_reg <= awd_pkg::TANH_ROM[a1_reg];
                end
                awd_pkg::CURVE_CLAMP, awd_pkg::CURVE_EXP:
                begin
                    lo_reg <= awd_pkg::EXP_ROM[a0_reg];
                    nx_reg <= awd_pkg::EXP_ROM[a1_reg];
                end
            endcase
            frac10_reg  <= frac9_reg;
            over10_reg  <= over9_reg;
            clamp10_reg <= clamp9_reg;
        end

        if (adv[awd_pkg::ST_MUL])
        begin
            prod_reg    <= awd_pkg::PROD_W'(diff_c) * awd_pkg::PROD_W'(frac10_reg);
            up_reg      <= up_c;
            lo11_reg    <= lo_reg;
            over11_reg  <= over10_reg;
            clamp11_reg <= clamp10_reg;
        end

        if (adv[awd_pkg::ST_SHAPE])
            shaped_reg <= shaped_c;

        if (adv[awd_pkg::ST_LEVEL])
            lvl_reg <= lp_c[awd_pkg::LEVEL_SHIFT +: awd_pkg::LVL_W];

        if (adv[awd_pkg::ST_OUT])
            sample_out_reg <= sample_out_next;
    end

endmodule
